// ===== hw/rtl/tsq_pkg.sv =====
// tsq_pkg: opcodes, result status codes, controller states and the
// command and status structs shared by the two-stack queue modules.
// no dependencies
package tsq_pkg;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ,
    S_DEQ,
    S_POP,
    S_MOVE_RD,
    S_MOVE_WR
  } state_t;

  typedef enum logic [1:0] {
    RES_ENQ_OK,
    RES_OVERFLOW,
    RES_UNDERFLOW,
    RES_POP
  } res_kind_t;

  typedef struct packed {
    logic      load_item;
    logic      push_in;
    logic      pop_out;
    logic      move_rd;
    logic      move_wr;
    logic      load_res;
    res_kind_t res_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic in_full;
    logic in_empty;
    logic out_empty;
    logic slot_free;
  } dp_stat_t;

endpackage

// ===== hw/rtl/tsq_ctrl.sv =====
// tsq_ctrl: state machine that sequences enqueue, dequeue and the
// input-to-output stack transfer. depends on tsq_pkg
module tsq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              opcode,
  input  tsq_pkg::dp_stat_t stat,
  output logic              in_stall,
  output tsq_pkg::dp_cmd_t  cmd
);
  import tsq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (opcode == OP_DEQ) ? S_DEQ : S_ENQ;
        end
      end
      S_ENQ: begin
        if (stat.slot_free) begin
          state_next = S_IDLE;
        end
      end
      S_DEQ: begin
        if (!stat.out_empty) begin
          state_next = S_POP;
        end else if (!stat.in_empty) begin
          state_next = S_MOVE_RD;
        end else if (stat.slot_free) begin
          state_next = S_IDLE;
        end
      end
      S_POP: begin
        if (stat.slot_free) begin
          state_next = S_IDLE;
        end
      end
      S_MOVE_RD: begin
        state_next = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        state_next = stat.in_empty ? S_DEQ : S_MOVE_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load_item = in_valid;
      end
      S_ENQ: begin
        if (stat.slot_free) begin
          cmd.load_res = 1'b1;
          if (stat.in_full) begin
            cmd.res_kind = RES_OVERFLOW;
          end else begin
            cmd.push_in  = 1'b1;
            cmd.res_kind = RES_ENQ_OK;
          end
        end
      end
      S_DEQ: begin
        if (!stat.out_empty) begin
          cmd.pop_out = 1'b1;
        end else if (stat.in_empty && stat.slot_free) begin
          cmd.load_res = 1'b1;
          cmd.res_kind = RES_UNDERFLOW;
        end
      end
      S_POP: begin
        if (stat.slot_free) begin
          cmd.load_res = 1'b1;
          cmd.res_kind = RES_POP;
        end
      end
      S_MOVE_RD: begin
        cmd.move_rd = 1'b1;
      end
      S_MOVE_WR: begin
        cmd.move_wr = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/tsq_dp.sv =====
// tsq_dp: the two stack memories with their counters, the item register
// and the result register. depends on tsq_pkg
module tsq_dp #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic signed [31:0]  value,
  input  tsq_pkg::dp_cmd_t    cmd,
  output tsq_pkg::dp_stat_t   stat,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic signed [31:0]  data_out
);
  import tsq_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic signed [31:0] item_value;
  logic [CW-1:0]      in_count, out_count;
  logic [CW-1:0]      in_top, out_top;
  logic [31:0]        in_mem  [STACK_DEPTH];
  logic [31:0]        out_mem [STACK_DEPTH];
  logic [31:0]        in_rdata, out_rdata;
  status_t            res_status;
  logic signed [31:0] res_data;

  assign in_top  = in_count - CW'(1);
  assign out_top = out_count - CW'(1);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_value <= value;
    end
  end

  // input stack
  always_ff @(posedge clk) begin
    if (cmd.push_in) begin
      in_mem[in_count[AW-1:0]] <= item_value;
    end
    if (cmd.move_rd) begin
      in_rdata <= in_mem[in_top[AW-1:0]];
    end
  end

  // output stack
  always_ff @(posedge clk) begin
    if (cmd.move_wr) begin
      out_mem[out_count[AW-1:0]] <= in_rdata;
    end
    if (cmd.pop_out) begin
      out_rdata <= out_mem[out_top[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_count  <= '0;
      out_count <= '0;
    end else begin
      if (cmd.push_in) begin
        in_count <= in_count + CW'(1);
      end else if (cmd.move_rd) begin
        in_count <= in_top;
      end
      if (cmd.move_wr) begin
        out_count <= out_count + CW'(1);
      end else if (cmd.pop_out) begin
        out_count <= out_top;
      end
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_res) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      unique case (cmd.res_kind)
        RES_ENQ_OK: begin
          res_status <= ST_OK;
          res_data   <= '0;
        end
        RES_OVERFLOW: begin
          res_status <= ST_OVERFLOW;
          res_data   <= '0;
        end
        RES_UNDERFLOW: begin
          res_status <= ST_UNDERFLOW;
          res_data   <= '1;
        end
        RES_POP: begin
          res_status <= ST_OK;
          res_data   <= $signed(out_rdata);
        end
      endcase
    end
  end

  assign status   = res_status;
  assign data_out = res_data;

  assign stat.in_full   = (in_count == CW'(STACK_DEPTH));
  assign stat.in_empty  = (in_count == '0);
  assign stat.out_empty = (out_count == '0);
  assign stat.slot_free = !out_valid || !out_stall;

endmodule

// ===== hw/rtl/two_stack_queue.sv =====
// two_stack_queue: top level of the queue built from two bounded stacks,
// joining tsq_ctrl and tsq_dp. depends on tsq_pkg, tsq_ctrl, tsq_dp
//
// A FIFO made of two STACK_DEPTH-deep stacks; each input beat (enqueue or
// dequeue) gives one result beat with a status and a data word. Items are
// handled one at a time: an enqueue pushes onto the input stack, a dequeue
// pops the output stack, and a dequeue that finds the output stack empty
// first moves the n entries of the input stack across, each with one read
// then one write through the single-port stack memories. A finished result
// sits in an output register, so the next item is taken while it waits. An
// enqueue to a full input stack is refused with overflow status even when
// the output stack has room; a dequeue of an empty queue returns underflow
// and -1.
module two_stack_queue #(
  parameter int STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [31:0] data_out
);
  import tsq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tsq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  tsq_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .data_out  (data_out)
  );

  // one item in flight at a time
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall
  ) else $error("input taken while an item was still in flight");

  a_status_code: assert property (
    @(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_OVERFLOW || status == ST_UNDERFLOW)
  ) else $error("result beat with an undefined status code");

  a_underflow_data: assert property (
    @(posedge clk) disable iff (rst)
    out_valid && status == ST_UNDERFLOW |-> data_out == -32'sd1
  ) else $error("underflow result without all-ones data");

  a_overflow_data: assert property (
    @(posedge clk) disable iff (rst)
    out_valid && status == ST_OVERFLOW |-> data_out == 32'sd0
  ) else $error("overflow result with non-zero data");

endmodule

// ===== dv/two_stack_queue_tb.sv =====
// two_stack_queue_tb: self-checking bench for the two-stack queue; a short
// table of directed beats then random traffic, checked against a queue model.
// depends on tsq_pkg and two_stack_queue
`timescale 1ns / 1ps

module two_stack_queue_tb;
  import tsq_pkg::*;

  localparam int DEPTH = 16;
  localparam int N_RANDOM = 1750;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    status_t     st;
    logic [31:0] word;
  } queue_result_t;

  typedef struct {
    logic        op;
    logic [31:0] val;
    int          reps;
    bit          pinned;
    status_t     st;
    logic [31:0] word;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               opcode = OP_ENQ;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic signed [31:0] data_out;

  // typed expectation travelling with the input beat
  bit                 beat_pinned = 1'b0;
  status_t            pinned_st = ST_OK;
  logic [31:0]        pinned_word = '0;

  logic [31:0]   in_stk [DEPTH];
  logic [31:0]   out_stk [DEPTH];
  int            in_depth = 0;
  int            out_depth = 0;
  queue_result_t due_results[$];
  stim_row_t     rows[$];
  int            err_count = 0;
  int            idle_cycles = 0;

  two_stack_queue #(.STACK_DEPTH(DEPTH)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .value    (value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .data_out (data_out)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic queue_result_t apply_queue_op(logic op, logic [31:0] val);
    queue_result_t r;
    r.st = ST_OK;
    r.word = '0;
    if (op == OP_ENQ) begin
      if (in_depth >= DEPTH) begin
        r.st = ST_OVERFLOW;
      end else begin
        in_stk[in_depth] = val;
        in_depth++;
      end
    end else begin
      if (out_depth == 0) begin
        while (in_depth > 0 && out_depth < DEPTH) begin
          in_depth--;
          out_stk[out_depth] = in_stk[in_depth];
          out_depth++;
        end
      end
      if (out_depth == 0) begin
        r.st = ST_UNDERFLOW;
        r.word = '1;
      end else begin
        out_depth--;
        r.word = out_stk[out_depth];
      end
    end
    return r;
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [31:0] draw_value();
    case ($urandom_range(0, 11))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_row(logic op, logic [31:0] val, int reps, bit pinned,
                         status_t st, logic [31:0] word);
    stim_row_t row;
    row.op = op;
    row.val = val;
    row.reps = reps;
    row.pinned = pinned;
    row.st = st;
    row.word = word;
    rows.push_back(row);
  endtask

  task automatic send_beat(logic op, logic [31:0] val, bit pinned, status_t st,
                           logic [31:0] word, bit quiet);
    int gap;
    in_valid <= 1'b1;
    opcode <= op;
    value <= val;
    beat_pinned <= pinned;
    pinned_st <= st;
    pinned_word <= word;
    do @(posedge clk); while (in_stall);
    gap = quiet ? 0 : draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side back-pressure
  initial begin : stall_gen
    int mode;
    forever begin
      mode = $urandom_range(0, 9);
      if (mode < 3) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 120)) @(posedge clk);
      end else if (mode == 9) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(20, 50)) @(posedge clk);
      end else begin
        repeat ($urandom_range(5, 30)) begin
          out_stall <= ($urandom_range(0, 99) < 35);
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    queue_result_t want;
    queue_result_t got_model;
    bit beat_in;
    bit beat_out;
    if (!rst) begin
      beat_in = in_valid && !in_stall;
      beat_out = out_valid && !out_stall;
      if (beat_out) begin
        if (due_results.size() == 0) begin
          $error("unexpected result beat: status %0d data_out %h", status, data_out);
          err_count++;
        end else begin
          want = due_results.pop_front();
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            err_count++;
          end
          if (data_out !== want.word) begin
            $error("data_out: expected %h, got %h", want.word, data_out);
            err_count++;
          end
        end
      end
      if (beat_in) begin
        got_model = apply_queue_op(opcode, value);
        if (beat_pinned) begin
          want.st = pinned_st;
          want.word = pinned_word;
          due_results.push_back(want);
        end else begin
          due_results.push_back(got_model);
        end
      end
      if (beat_in || beat_out) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  initial begin : driver
    int sent;
    int enq_pct;
    int run_len;
    bit quiet;
    logic op;

    // empty after reset, extremes, overflow with room left on the output stack
    add_row(OP_DEQ, 32'h0000_0000, 1, 1, ST_UNDERFLOW, 32'hFFFF_FFFF);
    add_row(OP_ENQ, 32'h7FFF_FFFF, 1, 1, ST_OK, 32'h0);
    add_row(OP_ENQ, 32'h8000_0000, 1, 1, ST_OK, 32'h0);
    add_row(OP_ENQ, 32'h0000_0000, 1, 1, ST_OK, 32'h0);
    add_row(OP_ENQ, 32'hFFFF_FFFF, 1, 1, ST_OK, 32'h0);
    add_row(OP_DEQ, 32'hFFFF_FFFF, 1, 1, ST_OK, 32'h7FFF_FFFF);
    add_row(OP_DEQ, 32'h0000_0000, 1, 1, ST_OK, 32'h8000_0000);
    add_row(OP_ENQ, 32'h5A5A_0000, DEPTH, 0, ST_OK, 32'h0);
    add_row(OP_ENQ, 32'hDEAD_BEEF, 1, 1, ST_OVERFLOW, 32'h0);
    add_row(OP_DEQ, 32'h0000_0000, 1, 1, ST_OK, 32'h0000_0000);
    add_row(OP_DEQ, 32'h0000_0000, 1, 1, ST_OK, 32'hFFFF_FFFF);
    add_row(OP_DEQ, 32'h0000_0000, 1, 1, ST_OK, 32'h5A5A_0000);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      for (int k = 0; k < rows[i].reps; k++) begin
        send_beat(rows[i].op, rows[i].val + k, rows[i].pinned, rows[i].st,
                  rows[i].word, 1'b0);
      end
    end

    // runs with a shifting enqueue bias so the stacks sweep from empty to full
    sent = 0;
    while (sent < N_RANDOM) begin
      case ($urandom_range(0, 4))
        0:       enq_pct = 15;
        1:       enq_pct = 40;
        2:       enq_pct = 55;
        3:       enq_pct = 75;
        default: enq_pct = 95;
      endcase
      run_len = $urandom_range(10, 80);
      quiet = ($urandom_range(0, 3) == 0);
      repeat (run_len) begin
        op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
        send_beat(op, draw_value(), 1'b0, ST_OK, 32'h0, quiet);
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
